### sv/adcwin_pkg.sv
package adcwin_pkg;

   localparam int WINDOW_DEPTH  = 16;
   localparam int ADC_FULL_CODE = 4095;

   localparam int SAMPLE_W = 12;
   localparam int MV_W     = 16;

   localparam logic [MV_W-1:0] FULL_SCALE_RESET = 16'd3300;

   // ring position; a one-entry window still gets a one-bit index
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   // running sum holds WINDOW_DEPTH full-code samples
   localparam int SUM_W  = $clog2(WINDOW_DEPTH * ADC_FULL_CODE + 1);
   localparam int PROD_W = SUM_W + MV_W;

   localparam int DIVISOR = WINDOW_DEPTH * ADC_FULL_CODE;

   // floor(p / DIVISOR) == (p * DIV_RECIP) >> DIV_SHIFT for any p below 2**PROD_W
   localparam int DIV_SHIFT = PROD_W + $clog2(DIVISOR);
   localparam int RECIP_W   = PROD_W + 1;
   localparam int QPROD_W   = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
   } sum_item_type;

   typedef struct packed {
      logic            valid;
      logic [MV_W-1:0] millivolts;
   } result_type;

endpackage

### sv/adcwin_if.sv
interface adcwin_req_if import adcwin_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                buffer_end;

   modport source (output valid, output sample, output buffer_end, input ready);
   modport sink   (input valid, input sample, input buffer_end, output ready);
endinterface

interface adcwin_rsp_if import adcwin_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [MV_W-1:0] millivolts;

   modport source (output valid, output millivolts, input ready);
   modport sink   (input valid, input millivolts, output ready);
endinterface

### sv/adcwin_window.sv
module adcwin_window import adcwin_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_accept,
   input  logic [SAMPLE_W-1:0] in_sample,
   input  logic                in_last,
   output sum_item_type        sum_out
);

   logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff;

   logic [SLOT_W-1:0]       slot_ff;
   logic [WINDOW_DEPTH-1:0] vld_ff;

   // read/modify stage
   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_last_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic                s1_old_vld_ff;
   logic                s1_fwd_ff;
   logic [SAMPLE_W-1:0] s1_fwd_data_ff;

   logic [SUM_W-1:0] sum_ff;
   sum_item_type     sum_out_ff;

   logic [SAMPLE_W-1:0] old_sample;
   logic [SUM_W-1:0]    sum_in;
   logic [SLOT_W-1:0]   slot_in;
   logic                fwd_in;

   // same-entry write in flight: read returns stale data, take the writer's sample
   assign fwd_in = s1_valid_ff && (s1_slot_ff == slot_ff);

   assign slot_in = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);

   always_comb begin
      if (!s1_old_vld_ff) begin
         old_sample = '0;
      end else if (s1_fwd_ff) begin
         old_sample = s1_fwd_data_ff;
      end else begin
         old_sample = rdata_ff;
      end
      sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(s1_sample_ff);
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         rdata_ff <= mem[slot_ff];
      end
      if (advance && s1_valid_ff) begin
         mem[s1_slot_ff] <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff   <= in_sample;
         s1_last_ff     <= in_last;
         s1_slot_ff     <= slot_ff;
         s1_old_vld_ff  <= vld_ff[slot_ff];
         s1_fwd_ff      <= fwd_in;
         s1_fwd_data_ff <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff          <= '0;
         vld_ff           <= '0;
         s1_valid_ff      <= 1'b0;
         sum_ff           <= '0;
         sum_out_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff    <= in_accept;
         sum_out_ff.sum <= sum_in;
         if (in_accept) begin
            if (in_last) begin
               slot_ff <= '0;
               vld_ff  <= '0;
            end else begin
               slot_ff         <= slot_in;
               vld_ff[slot_ff] <= 1'b1;
            end
         end
         if (s1_valid_ff) begin
            sum_ff           <= s1_last_ff ? '0 : sum_in;
            sum_out_ff.valid <= s1_last_ff;
         end else begin
            sum_out_ff.valid <= 1'b0;
         end
      end
   end

   assign sum_out = sum_out_ff;

endmodule

### sv/adcwin_scale.sv
module adcwin_scale import adcwin_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  sum_item_type    sum_in,
   input  logic [MV_W-1:0] full_scale,
   output result_type      result
);

   // stage 1 holds the product, stage 2 the quotient
   logic [PROD_W-1:0] prod_ff;
   logic [MV_W-1:0]   q_ff;
   logic [1:0]        v_ff;

   // division by the constant as a multiply by its scaled reciprocal
   logic [QPROD_W-1:0] qprod;

   assign qprod = QPROD_W'(prod_ff) * QPROD_W'(DIV_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= PROD_W'(sum_in.sum) * PROD_W'(full_scale);
         q_ff    <= qprod[DIV_SHIFT +: MV_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[0], sum_in.valid};
      end
   end

   assign result.valid      = v_ff[1];
   assign result.millivolts = q_ff;

endmodule

### sv/adc_window_average_to_millivolts_top.sv
// Moving average of 12-bit ADC samples, scaled to millivolts. Each accepted
// item carries one sample and a buffer_end flag. Samples go into a 16-entry
// ring window (a 16x12 synchronous RAM plus per-entry valid flags) with a
// running sum; the sample flagged buffer_end is folded in first, then one
// result is produced: floor(sum * full_scale_mv / (16 * 4095)), and the
// window is emptied so the next buffer starts from all zeros. Entries not
// written since the last buffer end read as zero through their valid flags,
// so no clearing pass is needed after reset or between buffers. Throughput
// is one item per clock: the RAM is read at accept and written back as the
// item leaves the read/modify stage, with a bypass when the entry being read
// is the one being written. An accepted item passes the read/modify stage,
// the sum update, a 16x16 multiply by full scale, an exact division by the
// constant 16*4095 done as a 32x33 multiply by its scaled reciprocal, and
// the output register. The whole pipeline holds while a result sits in the
// output register and rsp_ch.ready is low; req_ch.ready then drops.
// full_scale_mv (reset 3300) is written through csr_wr_en/csr_wr_data; the user
// writes it while no item is in flight (the block itself does not enforce this).
module adc_window_average_to_millivolts_top import adcwin_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   adcwin_req_if.sink      req_ch,
   adcwin_rsp_if.source    rsp_ch,
   input  logic            csr_wr_en,
   input  logic [MV_W-1:0] csr_wr_data
);

   logic [MV_W-1:0] full_scale_ff;
   logic            rsp_valid_ff;
   logic [MV_W-1:0] rsp_mv_ff;

   logic         advance;
   logic         accept;
   sum_item_type sum_item;
   result_type   result;

   // pipeline moves unless a finished item is stuck at the output
   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign accept  = req_ch.valid && advance;

   assign req_ch.ready      = advance;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.millivolts = rsp_mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_wr_en) begin
         full_scale_ff <= csr_wr_data;
      end
   end

   adcwin_window u_window (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_accept (accept),
      .in_sample (req_ch.sample),
      .in_last   (req_ch.buffer_end),
      .sum_out   (sum_item)
   );

   adcwin_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .sum_in     (sum_item),
      .full_scale (full_scale_ff),
      .result     (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mv_ff <= result.millivolts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.valid;
      end
   end

endmodule

### tb/adcwin_mv_checker.sv
module adcwin_mv_checker import adcwin_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_buffer_end,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [MV_W-1:0]     rsp_millivolts,
   input  logic                csr_wr_en,
   input  logic [MV_W-1:0]     csr_wr_data,
   output int                  fail_count,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SAMPLE_W-1:0] win_entry [WINDOW_DEPTH];
   int                  win_slot;
   logic [SUM_W-1:0]    win_sum;
   logic [MV_W-1:0]     full_scale;
   logic [MV_W-1:0]     mv_due [$];

   always @(posedge clock) begin : track
      logic [63:0]     product;
      logic [MV_W-1:0] mv_exp;
      if (reset) begin
         foreach (win_entry[i]) win_entry[i] = '0;
         win_slot   = 0;
         win_sum    = '0;
         full_scale = FULL_SCALE_RESET;
         fail_count = 0;
         mv_due.delete();
      end else begin
         if (csr_wr_en) full_scale = csr_wr_data;

         if (req_valid && req_ready) begin
            // ring window: oldest entry leaves the sum, new sample enters
            win_sum = win_sum - SUM_W'(win_entry[win_slot]) + SUM_W'(req_sample);
            win_entry[win_slot] = req_sample;
            win_slot = (win_slot == WINDOW_DEPTH - 1) ? 0 : win_slot + 1;
            if (req_buffer_end) begin
               product = 64'(win_sum) * 64'(full_scale);
               mv_due.push_back(MV_W'(product / 64'(DIVISOR)));
               foreach (win_entry[i]) win_entry[i] = '0;
               win_slot = 0;
               win_sum  = '0;
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (mv_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result with none due, millivolts %0d", $realtime,
                           rsp_millivolts);
               fail_count++;
            end else begin
               mv_exp = mv_due.pop_front();
               if (rsp_millivolts !== mv_exp) begin
                  if (fail_count < 10)
                     $display("%0t: millivolts mismatch, expected %0d actual %0d",
                              $realtime, mv_exp, rsp_millivolts);
                  fail_count++;
               end
            end
         end
      end
      pending = mv_due.size();
   end

endmodule

### tb/tb_adc_window_average_to_millivolts_top.sv
module tb_adc_window_average_to_millivolts_top import adcwin_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // settle this long after the last result, to let the pipeline empty
   localparam int LAT_PAD  = 30;
   // length of the long receiver hold-off, in cycles
   localparam int HOLD_LEN = 300;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_wr_en;
   logic [MV_W-1:0] csr_wr_data;

   // idle percentages per cycle for sender and receiver
   int tx_idle_pct;
   int rx_idle_pct;
   // hold-off request from the stimulus, consumed by the ready process
   bit rx_hold_req;
   int rx_hold_left = 0;

   int fail_count;
   int pending;

   adcwin_req_if req_if ();
   adcwin_rsp_if rsp_if ();

   adc_window_average_to_millivolts_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // watches both channels and the register port, predicts and compares
   adcwin_mv_checker mv_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_sample     (req_if.sample),
      .req_buffer_end (req_if.buffer_end),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_millivolts (rsp_if.millivolts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver side. A hold-off request drops ready until the HOLD_LEN count
   // kept here runs out; otherwise ready idles at rx_idle_pct percent.
   always @(posedge clock) begin
      if (rx_hold_left > 0) begin
         rx_hold_left = rx_hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (rx_hold_req) begin
         rx_hold_req  = 1'b0;
         rx_hold_left = HOLD_LEN - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Samples: mostly uniform, with the code extremes weighted up.
   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return SAMPLE_W'(ADC_FULL_CODE);
         default: return SAMPLE_W'($urandom_range(ADC_FULL_CODE));
      endcase
   endfunction

   // Offer one item, with random idle cycles ahead of it, and wait for the
   // handshake. valid stays high into the next item when no gap is drawn.
   task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.sample     <= s;
      req_if.buffer_end <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Sender goes quiet until every due result is back, then lets the
   // pipeline settle. The first edge lets the checker see the last item.
   task automatic wait_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LAT_PAD) @(posedge clock);
   endtask

   // Register writes only go in with the block idle.
   task automatic set_full_scale(input logic [MV_W-1:0] mv);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mv;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Whole buffers with random content until n_items samples are sent.
   // Most are within the window; about one in eight overruns it and wraps.
   task automatic send_buffers(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
         for (int i = 0; i < len; i++) push_sample(rand_sample(), i == len - 1);
         sent += len;
      end
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.sample     = '0;
      req_if.buffer_end = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      tx_idle_pct       = 37;
      rx_idle_pct       = 53;
      rx_hold_req       = 1'b0;
      reset             = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed, full scale still at its reset value ---
      // one-sample buffer at full code: the other 15 entries count as zero
      push_sample(SAMPLE_W'(ADC_FULL_CODE), 1'b1);
      // one-sample buffer at zero
      push_sample('0, 1'b1);
      // 17 samples: the leading zero is overwritten on wrap, so the window
      // ends all full code and the result is exactly full scale
      push_sample('0, 1'b0);
      repeat (15) push_sample(SAMPLE_W'(ADC_FULL_CODE), 1'b0);
      push_sample(SAMPLE_W'(ADC_FULL_CODE), 1'b1);
      // short buffer, mid-scale
      push_sample(SAMPLE_W'(1), 1'b0);
      push_sample(SAMPLE_W'(2048), 1'b1);
      // zero full scale gives zero whatever the window holds
      set_full_scale('0);
      push_sample(SAMPLE_W'(ADC_FULL_CODE), 1'b1);

      // --- random buffers, largest full scale, sender 37 / receiver 53 ---
      set_full_scale('1);
      send_buffers(200);

      // --- random full scale, sender 53 / receiver 37 ---
      tx_idle_pct = 53;
      rx_idle_pct = 37;
      set_full_scale(MV_W'($urandom_range(65535)));
      send_buffers(200);

      // --- smallest nonzero full scale, no idling ---
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_full_scale(MV_W'(1));
      send_buffers(150);

      // --- back pressure: receiver holds off while short buffers keep
      //     coming, so the pipeline fills and req ready drops ---
      set_full_scale(FULL_SCALE_RESET);
      rx_hold_req = 1'b1;
      repeat (60) push_sample(rand_sample(), $urandom_range(3) != 0);
      push_sample(rand_sample(), 1'b1);
      // sender pauses here until every result is out
      wait_drain();

      // --- last random stretch ---
      tx_idle_pct = 20;
      rx_idle_pct = 20;
      set_full_scale(MV_W'($urandom_range(65535)));
      send_buffers(80);

      wait_drain();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
sv/adcwin_pkg.sv
sv/adcwin_if.sv
sv/adcwin_window.sv
sv/adcwin_scale.sv
sv/adc_window_average_to_millivolts_top.sv
tb/adcwin_mv_checker.sv
tb/tb_adc_window_average_to_millivolts_top.sv
